// ===== design/i2cmbs_pkg.sv =====
// Shared types, command codes and the opcode helper function of the I2C master byte sequencer.
`default_nettype none
package i2cmbs_pkg;

  localparam int unsigned HALF_PERIOD_W     = 12;
  localparam int unsigned PHASE_W           = 5;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned ERR_W             = 2;
  localparam int unsigned IN_TDATA_W        = 16;
  localparam int unsigned OUT_TDATA_W       = 16;
  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 12'd40;

  // Phase at which the ninth (acknowledge) clock of a byte begins.
  localparam logic [PHASE_W-1:0] PH_ACK = 5'd16;

  // Command opcodes as they arrive on the input channel.
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_STOP    = 3'd1;
  localparam logic [2:0] OP_RESTART = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  // Sequencer state: the command in progress, or idle.
  typedef enum logic [5:0] {
    CMD_IDLE    = 6'b000001,
    CMD_START   = 6'b000010,
    CMD_STOP    = 6'b000100,
    CMD_RESTART = 6'b001000,
    CMD_WRITE   = 6'b010000,
    CMD_READ    = 6'b100000
  } cmd_t;

  // Actions of one bus phase, produced by the phase decoder.
  typedef struct packed {
    logic scl_en;
    logic scl_low;
    logic sda_en;
    logic sda_low;
    logic shift_out;
    logic shift_in;
    logic err_load;
    logic ack_load;
    logic rx_load;
    logic ended;
  } phase_act_t;

  // Maps an opcode to its command; unknown opcodes map to idle.
  function automatic cmd_t op_to_cmd(input logic [2:0] op);
    cmd_t c;
    c = CMD_IDLE;
    case (op)
      OP_START:   c = CMD_START;
      OP_STOP:    c = CMD_STOP;
      OP_RESTART: c = CMD_RESTART;
      OP_WRITE:   c = CMD_WRITE;
      OP_READ:    c = CMD_READ;
      default:    c = CMD_IDLE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/i2cmbs_phase_dec.sv =====
// Phase decoder: line actions and completion of each command phase.
`default_nettype none
module i2cmbs_phase_dec (
  input  i2cmbs_pkg::cmd_t                     cmd,
  input  logic [i2cmbs_pkg::PHASE_W-1:0]       phase,
  input  logic                                 tx_msb,
  input  logic                                 nack,
  output i2cmbs_pkg::phase_act_t               act
);
  import i2cmbs_pkg::*;

  logic in_byte;
  logic even;

  assign in_byte = (phase < PH_ACK);
  assign even    = ~phase[0];

  always_comb begin
    act = '0;
    unique case (cmd)
      CMD_START: begin
        if (phase == 5'd0) begin
          act.sda_en = 1'b1; act.sda_low = 1'b1;
        end else if (phase == 5'd1) begin
          act.scl_en = 1'b1; act.scl_low = 1'b1;
        end
        act.ended = (phase >= 5'd2);
      end
      CMD_RESTART: begin
        if (phase == 5'd0) begin
          act.sda_en = 1'b1;
        end else if (phase == 5'd1) begin
          act.scl_en = 1'b1;
        end else if (phase == 5'd2) begin
          act.sda_en = 1'b1; act.sda_low = 1'b1;
        end else if (phase == 5'd3) begin
          act.scl_en = 1'b1; act.scl_low = 1'b1;
        end
        act.ended = (phase >= 5'd4);
      end
      CMD_STOP: begin
        if (phase == 5'd0) begin
          act.scl_en = 1'b1; act.scl_low = 1'b1;
        end else if (phase == 5'd1) begin
          act.sda_en = 1'b1; act.sda_low = 1'b1;
        end else if (phase == 5'd2) begin
          act.scl_en = 1'b1;
        end else if (phase == 5'd3) begin
          act.sda_en = 1'b1;
        end else if (phase == 5'd4) begin
          act.err_load = 1'b1;
        end
        act.ended = (phase >= 5'd8);
      end
      CMD_WRITE: begin
        if (in_byte) begin
          if (even) begin
            // The first bit leaves SCL where the previous command put it.
            act.scl_en    = (phase != 5'd0);
            act.scl_low   = 1'b1;
            act.sda_en    = 1'b1;
            act.sda_low   = ~tx_msb;
            act.shift_out = 1'b1;
          end else begin
            act.scl_en = 1'b1;
          end
        end else if (phase == PH_ACK) begin
          act.scl_en = 1'b1; act.scl_low = 1'b1;
          act.sda_en = 1'b1;
        end else if (phase == PH_ACK + 5'd1) begin
          act.scl_en = 1'b1;
        end else begin
          act.ack_load = 1'b1;
          act.scl_en   = 1'b1; act.scl_low = 1'b1;
          act.ended    = 1'b1;
        end
      end
      CMD_READ: begin
        if (in_byte) begin
          if (even) begin
            act.sda_en = (phase == 5'd0);
            act.scl_en = 1'b1;
          end else begin
            act.shift_in = 1'b1;
            act.scl_en   = 1'b1; act.scl_low = 1'b1;
          end
        end else if (phase == PH_ACK) begin
          act.sda_en = 1'b1; act.sda_low = ~nack;
        end else if (phase == PH_ACK + 5'd1) begin
          act.scl_en = 1'b1;
        end else if (phase == PH_ACK + 5'd2) begin
          act.scl_en = 1'b1; act.scl_low = 1'b1;
        end else begin
          act.sda_en  = 1'b1;
          act.rx_load = 1'b1;
          act.ended   = 1'b1;
        end
      end
      default: begin
        act.ended = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/i2c_master_byte_sequencer.sv =====
// Top level of the I2C master byte sequencer: input register, phase engine, result register.
// An accepted item waits in the input register; its result enters the result register when the item moves on.
// Throughput: one item per cycle while the result register is not stalled; each item is one bus tick
// and yields exactly one result, since only the phase decoder and a 12-bit tick compare sit between the two registers.
// Reset (rst_n low, synchronous) empties both registers, makes the sequencer idle,
// releases SCL and SDA, sets ack_bit to one and half_period to 40.
`default_nettype none
module i2c_master_byte_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: half_period.
  input  logic        cfg_wr_en,
  input  logic [i2cmbs_pkg::HALF_PERIOD_W-1:0] cfg_wr_data,
  // Input items, one per bus tick.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata, from bit 0 up: cmd_valid, tx_byte[7:0], sda_in, scl_in, zero fill.
  input  logic [i2cmbs_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: op.
  input  logic [2:0]  in_tuser,
  // tlast: read NACK request, SDA is released after the byte instead of an ACK.
  input  logic        in_tlast,
  // Result items.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata, from bit 0 up: scl_drive_low, sda_drive_low, busy_res, done_res,
  // rx_byte[7:0], ack_bit, frame_error[1:0], zero fill.
  output logic [i2cmbs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import i2cmbs_pkg::*;

  // Configuration register.
  logic [HALF_PERIOD_W-1:0] half_period_r;

  // Input register: one accepted item waiting to be processed.
  logic        s1_valid_r;
  logic        s1_cmd_valid_r;
  logic [2:0]  s1_op_r;
  logic [7:0]  s1_tx_r;
  logic        s1_last_r;
  logic        s1_sda_r;
  logic        s1_scl_r;

  // Sequencer state.
  cmd_t                     cmd_r, cmd_nxt;
  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic [HALF_PERIOD_W-1:0] tick_r, tick_nxt;
  logic [BYTE_W-1:0]        shift_r, shift_nxt;
  logic                     scl_low_r, scl_low_nxt;
  logic                     sda_low_r, sda_low_nxt;
  logic                     ack_r, ack_nxt;
  logic [ERR_W-1:0]         err_r, err_nxt;
  logic                     nack_r, nack_nxt;
  logic [BYTE_W-1:0]        rx_r, rx_nxt;

  // Result register.
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  // Step control.
  logic                     advance;
  logic                     idle;
  cmd_t                     new_cmd;
  logic                     start_take;
  logic [HALF_PERIOD_W-1:0] tick_inc;
  logic [HALF_PERIOD_W-1:0] limit;
  logic                     tick_hit;
  logic                     enter;
  cmd_t                     cmd_eval;
  logic [PHASE_W-1:0]       phase_eval;
  logic [BYTE_W-1:0]        shift_base;
  logic                     nack_eval;
  phase_act_t               act;
  logic                     done;

  // The item in the input register moves on whenever the result register is free
  // or being emptied this cycle, and the input register then takes the next item.
  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A command is only looked at while idle; unknown opcodes decode to idle and are dropped.
  assign idle       = (cmd_r == CMD_IDLE);
  assign new_cmd    = op_to_cmd(s1_op_r);
  assign start_take = idle && s1_cmd_valid_r && (new_cmd != CMD_IDLE);

  // Phase timer. A half_period of zero behaves as one tick per phase, and a smaller
  // value written mid-phase ends the phase as soon as the count reaches it.
  assign tick_inc = tick_r + 12'd1;
  assign limit    = (half_period_r == '0) ? 12'd1 : half_period_r;
  assign tick_hit = (tick_inc >= limit);
  assign enter    = start_take || (!idle && tick_hit);

  // Context of the phase being entered: a new command starts at phase zero with a
  // freshly loaded shift register, a running one steps to its next phase.
  always_comb begin
    cmd_eval   = cmd_r;
    phase_eval = phase_r + 5'd1;
    shift_base = shift_r;
    nack_eval  = nack_r;
    if (start_take) begin
      cmd_eval   = new_cmd;
      phase_eval = '0;
      if (new_cmd == CMD_WRITE) begin
        shift_base = s1_tx_r;
      end else if (new_cmd == CMD_READ) begin
        shift_base = '0;
        nack_eval  = s1_last_r;
      end
    end
  end

  i2cmbs_phase_dec u_phase_dec (
    .cmd    (cmd_eval),
    .phase  (phase_eval),
    .tx_msb (shift_base[BYTE_W-1]),
    .nack   (nack_eval),
    .act    (act)
  );

  always_comb begin
    cmd_nxt     = cmd_r;
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    scl_low_nxt = scl_low_r;
    sda_low_nxt = sda_low_r;
    ack_nxt     = ack_r;
    err_nxt     = err_r;
    nack_nxt    = nack_r;
    rx_nxt      = rx_r;
    done        = 1'b0;

    if (start_take) begin
      cmd_nxt   = new_cmd;
      phase_nxt = '0;
      tick_nxt  = '0;
      shift_nxt = shift_base;
      nack_nxt  = nack_eval;
    end else if (!idle) begin
      tick_nxt  = tick_hit ? '0 : tick_inc;
      phase_nxt = tick_hit ? phase_eval : phase_r;
    end

    if (enter) begin
      if (act.scl_en) begin
        scl_low_nxt = act.scl_low;
      end
      if (act.sda_en) begin
        sda_low_nxt = act.sda_low;
      end
      if (act.shift_out) begin
        shift_nxt = {shift_base[BYTE_W-2:0], 1'b0};
      end
      if (act.shift_in) begin
        shift_nxt = {shift_base[BYTE_W-2:0], s1_sda_r};
      end
      if (act.err_load) begin
        // Count of lines still held low after the stop condition.
        err_nxt = {1'b0, ~s1_sda_r} + {1'b0, ~s1_scl_r};
      end
      if (act.ack_load) begin
        ack_nxt = s1_sda_r;
      end
      if (act.rx_load) begin
        rx_nxt = shift_base;
      end
      if (act.ended) begin
        cmd_nxt   = CMD_IDLE;
        phase_nxt = '0;
        tick_nxt  = '0;
        done      = 1'b1;
      end
    end
  end

  // Result fields show the state after this tick's update.
  assign out_data_nxt = {1'b0, err_nxt, ack_nxt, rx_nxt, done,
                         (cmd_nxt != CMD_IDLE), sda_low_nxt, scl_low_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
    end else if (cfg_wr_en) begin
      half_period_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_valid_r <= in_tdata[0];
      s1_tx_r        <= in_tdata[8:1];
      s1_sda_r       <= in_tdata[9];
      s1_scl_r       <= in_tdata[10];
      s1_op_r        <= in_tuser;
      s1_last_r      <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= CMD_IDLE;
      phase_r   <= '0;
      tick_r    <= '0;
      shift_r   <= '0;
      scl_low_r <= 1'b0;
      sda_low_r <= 1'b0;
      ack_r     <= 1'b1;
      err_r     <= '0;
      nack_r    <= 1'b0;
      rx_r      <= '0;
    end else if (advance) begin
      cmd_r     <= cmd_nxt;
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      scl_low_r <= scl_low_nxt;
      sda_low_r <= sda_low_nxt;
      ack_r     <= ack_nxt;
      err_r     <= err_nxt;
      nack_r    <= nack_nxt;
      rx_r      <= rx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // An idle sequencer always has its phase and tick counters cleared.
  a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_IDLE) |-> (phase_r == '0 && tick_r == '0))
    else $error("idle sequencer with nonzero phase or tick count");

  // The sequencer state moves only when an item is processed.
  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(cmd_r) && $stable(phase_r) && $stable(tick_r)))
    else $error("sequencer state changed without a processed item");

  // Input back-pressure only arises from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled while result register could drain");

  // A completion result never reports the sequencer as busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[3]) |-> !out_data_r[2])
    else $error("done and busy reported together");

endmodule
`default_nettype wire

// ===== sim/tb_i2c_master_byte_sequencer.sv =====
// Self-checking testbench for the I2C master byte sequencer: tick stream, bus model, result check.
module tb_i2c_master_byte_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbs_pkg::*;

  // Number of bus phases that shift one byte, before the acknowledge clock.
  localparam int unsigned BYTE_PHASES = 16;
  // Rough number of random ticks after the directed part.
  localparam int unsigned RAND_TICKS = 1350;
  // Ticks fed under one random half-period setting before it changes.
  localparam int unsigned TICKS_PER_SETTING = 200;
  // Cycles to wait for stray results once everything expected has come.
  localparam int unsigned TAIL_CYCLES = 20;

  // One input item: one bus tick with an optional command and the sampled pins.
  typedef struct {
    logic       valid;
    logic [2:0] op;
    logic [7:0] tx;
    logic       last;
    logic       sda;
    logic       scl;
  } tick_item_t;

  // One result item, laid out as out_tdata[14:0] from the top bit down.
  typedef struct packed {
    logic [1:0] frame_error;
    logic       ack_bit;
    logic [7:0] rx_byte;
    logic       done;
    logic       busy;
    logic       sda_low;
    logic       scl_low;
  } bus_res_t;

  // Every input of the block starts at a known value, reset held low.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  i2c_master_byte_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Ticks waiting to be offered, and bus states waiting to be seen on the output.
  tick_item_t  tick_q[$];
  bus_res_t    bus_state_q[$];

  // Our own copy of the sequencer: command, phase position, shifter and line drives.
  cmd_t        seq_cmd;
  logic [4:0]  seq_phase;
  logic [3:0]  seq_bits;
  logic [7:0]  seq_shift;
  logic [11:0] seq_ticks;
  logic        seq_scl_low;
  logic        seq_sda_low;
  logic        seq_ack;
  logic [1:0]  seq_err;
  logic        seq_nack;
  logic [7:0]  seq_rx;
  logic [11:0] model_half;

  int unsigned gen_total;
  int unsigned bad_cnt;
  int unsigned checked_cnt;
  int unsigned setting_cnt;
  int unsigned nack_cnt;
  int unsigned taken_cnt[5];
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_calm;
  bit          out_calm;

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length between items: mostly none or short, now and then long.
  // In a calm stretch there are no gaps at all.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Actions taken on entering phase p of the current command. Returns 1 when the
  // command ends with this phase. sda and scl are the pin levels sampled this tick.
  function automatic bit enter_bus_phase(input logic [4:0] p, input logic sda,
                                         input logic scl);
    bit fin;
    fin = 1'b0;
    case (seq_cmd)
      CMD_START: begin
        if (p == 0) seq_sda_low = 1'b1;
        else if (p == 1) seq_scl_low = 1'b1;
        fin = (p >= 2);
      end
      CMD_RESTART: begin
        if (p == 0) seq_sda_low = 1'b0;
        else if (p == 1) seq_scl_low = 1'b0;
        else if (p == 2) seq_sda_low = 1'b1;
        else if (p == 3) seq_scl_low = 1'b1;
        fin = (p >= 4);
      end
      CMD_STOP: begin
        if (p == 0) seq_scl_low = 1'b1;
        else if (p == 1) seq_sda_low = 1'b1;
        else if (p == 2) seq_scl_low = 1'b0;
        else if (p == 3) seq_sda_low = 1'b0;
        // Count the lines that are still low once both have been released.
        else if (p == 4) seq_err = {1'b0, ~sda} + {1'b0, ~scl};
        fin = (p >= 8);
      end
      CMD_WRITE: begin
        if (p < BYTE_PHASES) begin
          if (!p[0]) begin
            // The very first data bit leaves SCL where it is.
            if (p != 0) seq_scl_low = 1'b1;
            seq_sda_low = ~seq_shift[7];
            seq_shift = {seq_shift[6:0], 1'b0};
            seq_bits = seq_bits + 4'd1;
          end else begin
            seq_scl_low = 1'b0;
          end
        end else if (p == BYTE_PHASES) begin
          seq_scl_low = 1'b1;
          seq_sda_low = 1'b0;
        end else if (p == BYTE_PHASES + 1) begin
          seq_scl_low = 1'b0;
        end else begin
          // Ninth clock: a high SDA means the slave did not acknowledge.
          seq_ack = sda;
          seq_scl_low = 1'b1;
          fin = 1'b1;
        end
      end
      CMD_READ: begin
        if (p < BYTE_PHASES) begin
          if (!p[0]) begin
            if (p == 0) seq_sda_low = 1'b0;
            seq_scl_low = 1'b0;
          end else begin
            seq_shift = {seq_shift[6:0], sda};
            seq_bits = seq_bits + 4'd1;
            seq_scl_low = 1'b1;
          end
        end else if (p == BYTE_PHASES) begin
          seq_sda_low = ~seq_nack;
        end else if (p == BYTE_PHASES + 1) begin
          seq_scl_low = 1'b0;
        end else if (p == BYTE_PHASES + 2) begin
          seq_scl_low = 1'b1;
        end else begin
          seq_sda_low = 1'b0;
          seq_rx = seq_shift;
          fin = 1'b1;
        end
      end
      default: fin = 1'b1;
    endcase
    return fin;
  endfunction

  // Advances the sequencer copy by one tick and returns the bus state after it.
  function automatic bus_res_t bus_tick(input logic valid, input logic [2:0] op,
                                        input logic [7:0] tx, input logic last,
                                        input logic sda, input logic scl);
    bus_res_t    r;
    bit          fin;
    logic [11:0] lim;
    fin = 1'b0;
    if (seq_cmd == CMD_IDLE) begin
      // Commands are only looked at when idle; unknown opcodes leave it idle.
      if (valid && op <= OP_READ) begin
        case (op)
          OP_START:   seq_cmd = CMD_START;
          OP_STOP:    seq_cmd = CMD_STOP;
          OP_RESTART: seq_cmd = CMD_RESTART;
          OP_WRITE:   seq_cmd = CMD_WRITE;
          default:    seq_cmd = CMD_READ;
        endcase
        taken_cnt[op]++;
        seq_phase = '0;
        seq_ticks = '0;
        seq_bits = '0;
        if (seq_cmd == CMD_WRITE) seq_shift = tx;
        if (seq_cmd == CMD_READ) begin
          seq_shift = '0;
          seq_nack = last;
        end
        fin = enter_bus_phase(5'd0, sda, scl);
      end
    end else begin
      // A zero half-period behaves as one tick per phase. A phase also ends at
      // once when the setting was lowered below the count already reached.
      lim = (model_half == 0) ? 12'd1 : model_half;
      seq_ticks = seq_ticks + 12'd1;
      if (seq_ticks >= lim) begin
        seq_ticks = '0;
        seq_phase = seq_phase + 5'd1;
        fin = enter_bus_phase(seq_phase, sda, scl);
      end
    end
    if (fin) begin
      if (seq_cmd == CMD_WRITE && seq_ack) nack_cnt++;
      seq_cmd = CMD_IDLE;
      seq_phase = '0;
      seq_ticks = '0;
    end
    r.scl_low = seq_scl_low;
    r.sda_low = seq_sda_low;
    r.busy = (seq_cmd != CMD_IDLE);
    r.done = fin;
    r.rx_byte = seq_rx;
    r.ack_bit = seq_ack;
    r.frame_error = seq_err;
    return r;
  endfunction

  // Number of phases a command walks through after the one it enters on.
  function automatic int unsigned cmd_phases(input logic [2:0] op);
    case (op)
      OP_START:   return 2;
      OP_STOP:    return 8;
      OP_RESTART: return 4;
      OP_WRITE:   return BYTE_PHASES + 2;
      OP_READ:    return BYTE_PHASES + 3;
      default:    return 0;
    endcase
  endfunction

  task automatic push_tick(input logic v, input logic [2:0] op, input logic [7:0] tx,
                           input logic last);
    tick_item_t it;
    it.valid = v;
    it.op = op;
    it.tx = tx;
    it.last = last;
    it.sda = $urandom_range(0, 1);
    it.scl = $urandom_range(0, 1);
    tick_q.push_back(it);
    gen_total++;
  endtask

  // Offers a command, then fills the ticks the command is expected to take so that
  // the next command lands on the first idle tick. Filler ticks now and then carry
  // a command too, which the busy sequencer must ignore.
  task automatic issue_cmd(input logic [2:0] op, input logic [7:0] tx, input logic last);
    int unsigned span;
    span = cmd_phases(op) * ((model_half == 0) ? 1 : model_half);
    push_tick(1'b1, op, tx, last);
    repeat (span) begin
      push_tick($urandom_range(0, 9) == 0, $urandom_range(0, 7), $urandom,
                $urandom_range(0, 1));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        push_tick(1'b0, $urandom_range(0, 7), $urandom, $urandom_range(0, 1));
      end
    end
  endtask

  // A well-formed bus transaction: start, address, up to three data bytes, maybe a
  // repeated start with one more byte, and a stop.
  task automatic bus_transfer();
    int         nbytes;
    int         i;
    logic [7:0] addr;
    addr = $urandom;
    nbytes = $urandom_range(0, 3);
    issue_cmd(OP_START, $urandom, $urandom_range(0, 1));
    issue_cmd(OP_WRITE, addr, $urandom_range(0, 1));
    for (i = 0; i < nbytes; i++) begin
      if (addr[0]) begin
        // The last byte of a read is normally not acknowledged.
        issue_cmd(OP_READ, $urandom, (i == nbytes - 1) || ($urandom_range(0, 4) == 0));
      end else begin
        issue_cmd(OP_WRITE, $urandom, $urandom_range(0, 1));
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      issue_cmd(OP_RESTART, $urandom, $urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0) issue_cmd(OP_WRITE, $urandom, $urandom_range(0, 1));
      else issue_cmd(OP_READ, $urandom, $urandom_range(0, 1));
    end
    issue_cmd(OP_STOP, $urandom, $urandom_range(0, 1));
  endtask

  // Waits until every tick has been taken and every result has come back.
  task automatic wait_drain();
    @(negedge clk);
    while (tick_q.size() != 0 || in_tvalid || bus_state_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes half_period while nothing is in flight and mirrors it in the model.
  task automatic set_half(input logic [11:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= $urandom;
    model_half = v;
    setting_cnt++;
    @(negedge clk);
  endtask

  // Driver: offers queued ticks, holding each one until it is taken. The expected
  // bus state is worked out at the edge where the item is accepted.
  always @(posedge clk) begin
    tick_item_t it;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        bus_state_q.push_back(bus_tick(in_tdata[0], in_tuser, in_tdata[8:1], in_tlast,
                                       in_tdata[9], in_tdata[10]));
        if ($urandom_range(0, 149) == 0) in_calm = ~in_calm;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          it = tick_q.pop_front();
          in_tdata <= {5'b0, it.scl, it.sda, it.tx, it.valid};
          in_tuser <= it.op;
          in_tlast <= it.last;
          in_tvalid <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with a randomly stalling ready and checks each one
  // against the oldest expected bus state.
  always @(posedge clk) begin
    bus_res_t got;
    bus_res_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = bus_res_t'(out_tdata[14:0]);
        checked_cnt++;
        if (bus_state_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10) begin
            $display("unexpected result %0d: tdata=%04h with nothing expected",
                     checked_cnt, out_tdata);
          end
        end else begin
          want = bus_state_q.pop_front();
          if (got.scl_low !== want.scl_low || got.sda_low !== want.sda_low ||
              got.busy !== want.busy || got.done !== want.done ||
              got.rx_byte !== want.rx_byte || got.ack_bit !== want.ack_bit ||
              got.frame_error !== want.frame_error) begin
            bad_cnt++;
            if (bad_cnt <= 10) begin
              $display("mismatch at result %0d: expected scl=%0d sda=%0d busy=%0d done=%0d",
                       checked_cnt, want.scl_low, want.sda_low, want.busy, want.done);
              $display("  rx=%02h ack=%0d ferr=%0d; got scl=%0d sda=%0d busy=%0d done=%0d",
                       want.rx_byte, want.ack_bit, want.frame_error, got.scl_low,
                       got.sda_low, got.busy, got.done);
              $display("  rx=%02h ack=%0d ferr=%0d", got.rx_byte, got.ack_bit,
                       got.frame_error);
            end
          end
        end
        if ($urandom_range(0, 149) == 0) out_calm = ~out_calm;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_goal;
    int unsigned rand_goal;
    int unsigned r;
    int          b;
    logic [11:0] hp;

    // Sequencer copy in its reset state.
    seq_cmd = CMD_IDLE;
    seq_phase = '0;
    seq_bits = '0;
    seq_shift = '0;
    seq_ticks = '0;
    seq_scl_low = 1'b0;
    seq_sda_low = 1'b0;
    seq_ack = 1'b1;
    seq_err = '0;
    seq_nack = 1'b0;
    seq_rx = '0;
    model_half = HALF_PERIOD_RST;
    gen_total = 0;
    bad_cnt = 0;
    checked_cnt = 0;
    setting_cnt = 0;
    nack_cnt = 0;
    taken_cnt = '{default: 0};
    in_gap = 0;
    out_stall = 0;
    in_calm = 1'b0;
    out_calm = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A start under the reset half-period of 40 ticks.
    issue_cmd(OP_START, 8'h00, 1'b0);
    wait_drain();

    // Directed pass at half_period zero: every command, byte extremes, both
    // acknowledge choices on reads, ignored unknown opcodes and a command with
    // the valid bit low.
    set_half('0);
    issue_cmd(OP_START, 8'hFF, 1'b1);
    issue_cmd(OP_WRITE, 8'hFF, 1'b0);
    issue_cmd(OP_WRITE, 8'h00, 1'b1);
    issue_cmd(OP_WRITE, 8'hA5, 1'b0);
    issue_cmd(OP_READ, 8'h00, 1'b0);
    issue_cmd(OP_READ, 8'hFF, 1'b1);
    issue_cmd(OP_RESTART, 8'h5A, 1'b0);
    for (b = OP_READ + 1; b < 8; b++) issue_cmd(b[2:0], 8'hFF, 1'b1);
    push_tick(1'b0, OP_START, 8'h00, 1'b0);
    issue_cmd(OP_STOP, 8'h00, 1'b0);
    wait_drain();

    // Longest half-period: a start sits in its first phase, and the next
    // setting cuts that phase short.
    set_half(12'hFFF);
    push_tick(1'b1, OP_START, 8'h00, 1'b0);
    repeat (40) push_tick($urandom_range(0, 1), $urandom_range(0, 7), $urandom,
                          $urandom_range(0, 1));
    wait_drain();

    // Random part: short half-periods mostly, so commands complete often.
    rand_goal = gen_total + RAND_TICKS;
    while (gen_total < rand_goal) begin
      r = $urandom_range(0, 9);
      if (r < 5) hp = 12'd1;
      else if (r < 7) hp = 12'd2;
      else if (r < 8) hp = 12'd3;
      else if (r < 9) hp = 12'd0;
      else hp = $urandom_range(4, 6);
      set_half(hp);
      phase_goal = gen_total + TICKS_PER_SETTING;
      while (gen_total < phase_goal) begin
        if ($urandom_range(0, 99) < 85) begin
          bus_transfer();
        end else begin
          // Noise: arbitrary commands at arbitrary times.
          repeat ($urandom_range(1, 12)) begin
            push_tick($urandom_range(0, 1), $urandom_range(0, 7), $urandom,
                      $urandom_range(0, 1));
          end
        end
      end
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d ticks checked under %0d half-period settings, %0d write NACKs seen",
             checked_cnt, setting_cnt, nack_cnt);
    $display("commands taken: start %0d, stop %0d, restart %0d, write %0d, read %0d",
             taken_cnt[OP_START], taken_cnt[OP_STOP], taken_cnt[OP_RESTART],
             taken_cnt[OP_WRITE], taken_cnt[OP_READ]);
    if (bad_cnt == 0 && bus_state_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
